### rtl/leader_cluster_2d_macros.svh
// Assertion helpers for the leader clustering block.
`ifndef LEADER_CLUSTER_2D_MACROS_SVH
`define LEADER_CLUSTER_2D_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define LC2D_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, gated off during reset.
`define LC2D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/lc2d_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lc2d_pkg
// Shared types and constants of the leader clustering block.
// ---------------------------------------------------------------------------
package lc2d_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int PT_AW          = 5;   // widest point address
    localparam int COORD_W        = 32;
    localparam int THR_W          = 31;
    localparam int IDX_W          = 5;
    localparam int VAL_W          = 6;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMIT_SIZES = 1'd1;

    localparam logic KIND_LABEL = 1'b0;
    localparam logic KIND_SIZE  = 1'b1;

    typedef struct packed {
        logic             store;     // write incoming point
        logic [PT_AW-1:0] addr;      // point / cluster address
        logic             seed_lbl;  // give seed its label
        logic             seed_ld;   // latch seed coordinates
        logic             cmp;       // test point against seed
        logic             push_lbl;  // load label result
        logic             push_size; // load size result
        logic             push_last; // result ends the run
        logic             clear;     // drop the set
    } t_cmd;

    typedef struct packed {
        logic [PT_AW:0] cnt;         // stored points
        logic [PT_AW:0] clu;         // clusters opened
        logic           out_free;    // output register can take a result
    } t_stat;

endpackage

### rtl/lc2d_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lc2d_dp
// Point stores, label and size arrays, seed compare and output register.
// ---------------------------------------------------------------------------
module lc2d_dp #(
    parameter int MAX_POINTS = lc2d_pkg::MAX_POINTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lc2d_pkg::t_cmd                    i_cmd,
    output lc2d_pkg::t_stat                   o_stat,
    input  logic signed [lc2d_pkg::COORD_W-1:0] i_x,
    input  logic signed [lc2d_pkg::COORD_W-1:0] i_y,
    input  logic [lc2d_pkg::THR_W-1:0]        i_thr,
    input  logic                              i_m_ready,
    output logic                              o_m_valid,
    output logic                              o_kind,
    output logic [lc2d_pkg::IDX_W-1:0]        o_index,
    output logic [lc2d_pkg::VAL_W-1:0]        o_value,
    output logic                              o_ovf,
    output logic                              o_last
);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic signed [lc2d_pkg::COORD_W-1:0] r_xm [MAX_POINTS];
    logic signed [lc2d_pkg::COORD_W-1:0] r_ym [MAX_POINTS];
    logic signed [lc2d_pkg::COORD_W-1:0] r_rd_x, r_rd_y, r_sx, r_sy;
    logic [CW-1:0] r_lbl  [MAX_POINTS];
    logic [CW-1:0] r_size [MAX_POINTS];
    logic [CW-1:0] r_cnt, r_clu, r_seed;
    logic          r_drop;
    logic          r_ov;

    logic [AW-1:0] w_addr, w_sidx;
    logic [CW-1:0] w_lbl, w_new, w_size;
    logic signed [lc2d_pkg::COORD_W:0] w_dx, w_dy;
    logic [lc2d_pkg::COORD_W:0] w_ax, w_ay;
    logic w_near, w_join, w_room;

    assign w_addr = i_cmd.addr[AW-1:0];
    assign w_lbl  = r_lbl[w_addr];
    assign w_new  = r_clu + CW'(1);
    assign w_room = (r_cnt < CW'(MAX_POINTS));

    // both coordinates sign-extended to 33 bits: difference never wraps
    assign w_dx = {r_rd_x[lc2d_pkg::COORD_W-1], r_rd_x} - {r_sx[lc2d_pkg::COORD_W-1], r_sx};
    assign w_dy = {r_rd_y[lc2d_pkg::COORD_W-1], r_rd_y} - {r_sy[lc2d_pkg::COORD_W-1], r_sy};
    assign w_ax = w_dx[lc2d_pkg::COORD_W] ? unsigned'(-w_dx) : unsigned'(w_dx);
    assign w_ay = w_dy[lc2d_pkg::COORD_W] ? unsigned'(-w_dy) : unsigned'(w_dy);
    assign w_near = (w_ax <= {2'b00, i_thr}) && (w_ay <= {2'b00, i_thr});
    assign w_join = i_cmd.cmp && (w_lbl == '0) && w_near;

    // single size-array read port: output address, or the cluster being counted
    always_comb begin
        if (i_cmd.push_size) begin
            w_sidx = w_addr;
        end else if (i_cmd.seed_lbl) begin
            w_sidx = r_clu[AW-1:0];
        end else begin
            w_sidx = AW'(r_seed - CW'(1));
        end
    end
    assign w_size = r_size[w_sidx];

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && w_room) begin
            r_xm[r_cnt[AW-1:0]] <= i_x;
            r_ym[r_cnt[AW-1:0]] <= i_y;
        end
        r_rd_x <= r_xm[w_addr];
        r_rd_y <= r_ym[w_addr];
        if (i_cmd.seed_ld) begin
            r_sx <= r_rd_x;
            r_sy <= r_rd_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < MAX_POINTS; k++) begin
                r_lbl[k]  <= '0;
                r_size[k] <= '0;
            end
            r_cnt  <= '0;
            r_clu  <= '0;
            r_drop <= 1'b0;
            r_seed <= '0;
        end else begin
            if (i_cmd.store) begin
                if (w_room) begin
                    r_cnt <= r_cnt + CW'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.seed_lbl) begin
                if (w_lbl == '0) begin
                    r_lbl[w_addr] <= w_new;
                    r_clu         <= w_new;
                    r_seed        <= w_new;
                    r_size[w_sidx] <= w_size + CW'(1);
                end else begin
                    r_seed <= w_lbl;
                end
            end
            if (w_join) begin
                r_lbl[w_addr]  <= r_seed;
                r_size[w_sidx] <= w_size + CW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.push_lbl || i_cmd.push_size) begin
            r_ov <= 1'b1;
        end else if (i_m_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_lbl || i_cmd.push_size) begin
            o_kind  <= i_cmd.push_size ? lc2d_pkg::KIND_SIZE : lc2d_pkg::KIND_LABEL;
            o_index <= lc2d_pkg::IDX_W'(w_addr);
            o_value <= lc2d_pkg::VAL_W'(i_cmd.push_size ? w_size : w_lbl);
            o_ovf   <= r_drop;
            o_last  <= i_cmd.push_last;
        end
    end

    assign o_m_valid       = r_ov;
    assign o_stat.cnt      = (lc2d_pkg::PT_AW + 1)'(r_cnt);
    assign o_stat.clu      = (lc2d_pkg::PT_AW + 1)'(r_clu);
    assign o_stat.out_free = !r_ov || i_m_ready;
endmodule

### rtl/lc2d_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lc2d_ctrl
// Sequencer: load, seed-versus-rest scan, result emission, clear.
// ---------------------------------------------------------------------------
module lc2d_ctrl #(
    parameter int MAX_POINTS = lc2d_pkg::MAX_POINTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_valid,
    input  logic            i_s_last,
    output logic            o_s_ready,
    input  logic            i_emit_sizes,
    input  lc2d_pkg::t_stat i_stat,
    output lc2d_pkg::t_cmd  o_cmd
);
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_SEED  = 3'd1;
    localparam logic [2:0] S_LATCH = 3'd2;
    localparam logic [2:0] S_RDJ   = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_OUTL  = 3'd5;
    localparam logic [2:0] S_OUTS  = 3'd6;
    localparam logic [2:0] S_CLR   = 3'd7;

    logic [2:0]    r_st, n_st;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_e, n_e;
    logic [CW-1:0] w_n, w_c, w_i1, w_j1, w_e1;

    assign w_n  = CW'(i_stat.cnt);
    assign w_c  = CW'(i_stat.clu);
    assign w_i1 = r_i + CW'(1);
    assign w_j1 = r_j + CW'(1);
    assign w_e1 = r_e + CW'(1);
    assign o_s_ready = (r_st == S_LOAD);

    always_comb begin
        n_st  = r_st;
        n_i   = r_i;
        n_j   = r_j;
        n_e   = r_e;
        o_cmd = '0;
        case (r_st)
            S_LOAD: begin
                o_cmd.store = i_s_valid;
                if (i_s_valid && i_s_last) begin
                    n_i  = '0;
                    n_st = S_SEED;
                end
            end
            S_SEED: begin
                o_cmd.addr     = lc2d_pkg::PT_AW'(r_i);
                o_cmd.seed_lbl = 1'b1;
                n_st           = S_LATCH;
            end
            S_LATCH, S_CMP: begin
                o_cmd.seed_ld = (r_st == S_LATCH);
                o_cmd.cmp     = (r_st == S_CMP);
                o_cmd.addr    = lc2d_pkg::PT_AW'(r_st == S_LATCH ? r_i : r_j);
                n_j           = (r_st == S_LATCH) ? w_i1 : w_j1;
                if (n_j < w_n) begin
                    n_st = S_RDJ;
                end else if (w_i1 < w_n) begin
                    n_i  = w_i1;
                    n_st = S_SEED;
                end else begin
                    n_e  = '0;
                    n_st = S_OUTL;
                end
            end
            S_RDJ: begin
                o_cmd.addr = lc2d_pkg::PT_AW'(r_j);
                n_st       = S_CMP;
            end
            S_OUTL: begin
                o_cmd.addr = lc2d_pkg::PT_AW'(r_e);
                if (i_stat.out_free) begin
                    o_cmd.push_lbl  = 1'b1;
                    o_cmd.push_last = (w_e1 == w_n) && !i_emit_sizes;
                    n_e             = w_e1;
                    if (w_e1 == w_n) begin
                        n_e  = '0;
                        n_st = i_emit_sizes ? S_OUTS : S_CLR;
                    end
                end
            end
            S_OUTS: begin
                o_cmd.addr = lc2d_pkg::PT_AW'(r_e);
                if (i_stat.out_free) begin
                    o_cmd.push_size = 1'b1;
                    o_cmd.push_last = (w_e1 == w_c);
                    n_e             = w_e1;
                    if (w_e1 == w_c) begin
                        n_st = S_CLR;
                    end
                end
            end
            S_CLR: begin
                o_cmd.clear = 1'b1;
                n_st        = S_LOAD;
            end
            default: begin
                n_st = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD;
            r_i  <= '0;
            r_j  <= '0;
            r_e  <= '0;
        end else begin
            r_st <= n_st;
            r_i  <= n_i;
            r_j  <= n_j;
            r_e  <= n_e;
        end
    end
endmodule

### rtl/leader_cluster_2d.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// leader_cluster_2d
// Leader clustering of 2-D Q16.16 points under a per-axis threshold.
// ---------------------------------------------------------------------------
// Points stream in one per cycle while loading; the transaction with tlast set
// closes the set. Each point in index order is a seed (opening cluster N+1 if
// still unlabeled) and is compared against every later point: each pair takes
// one store read and one compare on 33-bit exact differences, after a seed
// label step and a seed latch step per seed. Clustering is followed by one
// result per cycle (labels, then sizes when enabled) as the sink takes them,
// then a clear step before s_axis_tready rises again. Points beyond MAX_POINTS
// are dropped and reported on every result of that set. Write configuration
// only while idle.
// ---------------------------------------------------------------------------
module leader_cluster_2d #(
    parameter int MAX_POINTS = lc2d_pkg::MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config: index 0 threshold (31 bits), index 1 emit_sizes (bit 0)
    input  logic                              i_cfg_we,
    input  logic [lc2d_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lc2d_pkg::THR_W-1:0]        i_cfg_data,
    // input points
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] x_coord, [63:32] y_coord
    input  logic        s_axis_tlast,   // last_point
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [4:0] index, [10:5] value, rest zero
    output logic [1:0]  m_axis_tuser,   // [0] kind, [1] overflow
    output logic        m_axis_tlast    // last_result
);
    logic [lc2d_pkg::THR_W-1:0] r_thr;
    logic                       r_emit;
    lc2d_pkg::t_cmd             w_cmd;
    lc2d_pkg::t_stat            w_stat;
    logic [lc2d_pkg::IDX_W-1:0] w_index;
    logic [lc2d_pkg::VAL_W-1:0] w_value;
    logic                       w_kind, w_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= '0;
            r_emit <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lc2d_pkg::REG_THRESHOLD:  r_thr  <= i_cfg_data;
                lc2d_pkg::REG_EMIT_SIZES: r_emit <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    lc2d_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .i_s_last     (s_axis_tlast),
        .o_s_ready    (s_axis_tready),
        .i_emit_sizes (r_emit),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    lc2d_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .i_x       (signed'(s_axis_tdata[31:0])),
        .i_y       (signed'(s_axis_tdata[63:32])),
        .i_thr     (r_thr),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_kind    (w_kind),
        .o_index   (w_index),
        .o_value   (w_value),
        .o_ovf     (w_ovf),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b00000, w_value, w_index};
    assign m_axis_tuser = {w_ovf, w_kind};
endmodule

### rtl/lc2d_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lc2d_checker
// Port-level checks of the leader clustering block, bound to the top level.
// ---------------------------------------------------------------------------
`include "leader_cluster_2d_macros.svh"

module lc2d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    // a pending result is not withdrawn
    `LC2D_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // closing point stops intake until the run is done
    `LC2D_ASSERT_NEXT(a_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
    // labels start at one
    `LC2D_ASSERT_IMPL(a_lbl, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[10:5] != 6'd0)
    // every cluster has at least one point, at most 32
    `LC2D_ASSERT_IMPL(a_size, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[10:5] != 6'd0) && (m_axis_tdata[10:5] <= 6'd32))
endmodule

bind leader_cluster_2d lc2d_checker u_lc2d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
